### hdl/abpf_pkg.sv
// ----------------------------------------------------------------------------
// Archive block plaintext filter - shared definitions
// Widths, verdict and register codes, pipeline buses and signature lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package abpf_pkg;

    // Field widths
    localparam int HEAD_W     = 64;
    localparam int VERD_W     = 2;
    localparam int METHOD_W   = 6;
    localparam int KIND_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Code length stream: bytes 0..15 from bit 2 on, padded with zeros
    localparam int NIB_W      = 4;
    localparam int STREAM_W   = 160;
    localparam int NUM_LENS   = 20;
    localparam int MAX_LEN    = 15;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 5;
    localparam int LEFT_W     = 16;

    // Pipeline shape
    localparam int TOKENS_PER_STAGE = 4;
    localparam int PARSE_STAGES     = 5;
    localparam int KRAFT_STEPS      = 5;
    localparam int KRAFT_STAGES     = 3;
    localparam int PIPE_LATENCY     = 2 + PARSE_STAGES + KRAFT_STAGES;

    localparam logic [METHOD_W-1:0] METHOD_STORED = 6'h30;
    localparam logic [METHOD_W-1:0] METHOD_RESET  = 6'h30;
    localparam logic [KIND_W-1:0]   KIND_RESET    = 4'd2;
    localparam logic [NIB_W-1:0]    ESC_NIB       = 4'hF;

    // File kinds with a known magic number (mp3 has none)
    localparam logic [KIND_W-1:0] KIND_JPEG = 4'd1;
    localparam logic [KIND_W-1:0] KIND_PNG  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_PDF  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_ZIP  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_GZ   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_BMP  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_GIF  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_7Z   = 4'd9;
    localparam logic [KIND_W-1:0] KIND_RAR  = 4'd10;

    typedef enum logic [VERD_W-1:0] {
        VERD_REJECT = 2'd0,
        VERD_STORED = 2'd1,
        VERD_PPM    = 2'd2,
        VERD_LZ     = 2'd3
    } t_verdict;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_METHOD = 2'd0,
        REG_KIND   = 2'd1
    } t_cfg_reg;

    typedef logic [MAX_LEN:1][CNT_W-1:0] t_counts;

    typedef struct packed {
        logic                valid;
        t_verdict            verdict;
        logic                lz_en;
        logic [STREAM_W-1:0] stream;
        logic [IDX_W-1:0]    idx;
        t_counts             cnt;
    } t_parse_bus;

    typedef struct packed {
        logic              valid;
        t_verdict          verdict;
        logic              lz_en;
        logic              fail;
        logic [LEFT_W-1:0] left;
        t_counts           cnt;
    } t_kraft_bus;

    // Compare the leading bytes with the magic number of the file kind
    function automatic logic sig_match(input logic [KIND_W-1:0] kind,
                                       input logic [HEAD_W-1:0] head);
        logic hit;
        unique case (kind)
            KIND_JPEG: hit = (head[63:40] == 24'hFFD8FF);
            KIND_PNG:  hit = (head == 64'h89504E470D0A1A0A);
            KIND_PDF:  hit = (head[63:24] == 40'h255044462D);
            KIND_ZIP:  hit = (head[63:32] == 32'h504B0304);
            KIND_GZ:   hit = (head[63:48] == 16'h1F8B);
            KIND_BMP:  hit = (head[63:48] == 16'h424D);
            KIND_GIF:  hit = (head[63:32] == 32'h47494638);
            KIND_7Z:   hit = (head[63:16] == 48'h377ABCAF271C);
            KIND_RAR:  hit = (head[63:16] == 48'h526172211A07);
            default:   hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

`default_nettype wire

### hdl/abpf_front.sv
// ----------------------------------------------------------------------------
// Front stage
// Decides the stored and PPM paths, flags LZ candidates and lines up the
// code length stream for the parse stages.
// ----------------------------------------------------------------------------
`default_nettype none

module abpf_front
    import abpf_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic [HEAD_W-1:0]   i_block_head,
    input  wire logic [HEAD_W-1:0]   i_block_tail,
    input  wire logic [METHOD_W-1:0] i_method,
    input  wire logic [KIND_W-1:0]   i_kind,
    output t_parse_bus               o_bus
);

    t_parse_bus r_bus;
    t_parse_bus n_bus;
    logic [7:0] b0;
    logic [7:0] b1;

    assign b0 = i_block_head[63:56];
    assign b1 = i_block_head[55:48];

    // Pick the path and set the early verdict
    always_comb begin
        n_bus         = '0;
        n_bus.valid   = i_valid;
        n_bus.verdict = VERD_REJECT;
        n_bus.lz_en   = 1'b0;
        priority if (i_method == METHOD_STORED) begin
            if (sig_match(i_kind, i_block_head)) begin
                n_bus.verdict = VERD_STORED;
            end
        end else if (b0[7]) begin
            if (b0[5] && !b1[7]) begin
                n_bus.verdict = VERD_PPM;
            end
        end else begin
            n_bus.lz_en = !b0[6];
        end
        n_bus.stream = {i_block_head[HEAD_W-3:0], i_block_tail,
                        {(STREAM_W - 2*HEAD_W + 2){1'b0}}};
        n_bus.idx    = '0;
        n_bus.cnt    = '0;
    end

    // Hold the valid flag under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus.valid <= n_bus.valid;
        end
    end

    // Advance the payload every cycle
    always_ff @(posedge i_clk) begin
        r_bus.verdict <= n_bus.verdict;
        r_bus.lz_en   <= n_bus.lz_en;
        r_bus.stream  <= n_bus.stream;
        r_bus.idx     <= n_bus.idx;
        r_bus.cnt     <= n_bus.cnt;
    end

    assign o_bus = r_bus;

endmodule

`default_nettype wire

### hdl/abpf_parse_stage.sv
// ----------------------------------------------------------------------------
// Code length parse stage
// Consumes up to four length tokens from the stream and counts each nonzero
// length; a fifteen escape gives either length fifteen or a zero run.
// ----------------------------------------------------------------------------
`default_nettype none

module abpf_parse_stage
    import abpf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_parse_bus i_bus,
    output t_parse_bus      o_bus
);

    t_parse_bus r_bus;
    t_parse_bus n_bus;

    // Walk the tokens of this stage
    always_comb begin
        logic [NIB_W-1:0] len;
        logic [NIB_W-1:0] z;
        logic [IDX_W:0]   run;
        n_bus = i_bus;
        for (int t = 0; t < TOKENS_PER_STAGE; t++) begin
            len = n_bus.stream[STREAM_W-1 -: NIB_W];
            z   = n_bus.stream[STREAM_W-1-NIB_W -: NIB_W];
            run = '0;
            if (n_bus.idx < IDX_W'(NUM_LENS)) begin
                if (len == ESC_NIB) begin
                    n_bus.stream = n_bus.stream << (2*NIB_W);
                    if (z == '0) begin
                        n_bus.cnt[MAX_LEN] = n_bus.cnt[MAX_LEN] + CNT_W'(1);
                        n_bus.idx          = n_bus.idx + IDX_W'(1);
                    end else begin
                        // zero run of z + 2, cut at the table end
                        run = {1'b0, n_bus.idx} + (IDX_W+1)'(z) + (IDX_W+1)'(2);
                        if (run > (IDX_W+1)'(NUM_LENS)) begin
                            n_bus.idx = IDX_W'(NUM_LENS);
                        end else begin
                            n_bus.idx = run[IDX_W-1:0];
                        end
                    end
                end else begin
                    n_bus.stream = n_bus.stream << NIB_W;
                    for (int k = 1; k <= MAX_LEN; k++) begin
                        if (len == NIB_W'(k)) begin
                            n_bus.cnt[k] = n_bus.cnt[k] + CNT_W'(1);
                        end
                    end
                    n_bus.idx = n_bus.idx + IDX_W'(1);
                end
            end
        end
    end

    // Hold the valid flag under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus.valid <= n_bus.valid;
        end
    end

    // Advance the payload every cycle
    always_ff @(posedge i_clk) begin
        r_bus.verdict <= n_bus.verdict;
        r_bus.lz_en   <= n_bus.lz_en;
        r_bus.stream  <= n_bus.stream;
        r_bus.idx     <= n_bus.idx;
        r_bus.cnt     <= n_bus.cnt;
    end

    assign o_bus = r_bus;

endmodule

`default_nettype wire

### hdl/abpf_kraft_stage.sv
// ----------------------------------------------------------------------------
// Kraft sum stage
// Runs five lengths of the prefix code check: left doubles and loses
// the count of each length; going below zero marks the table bad.
// ----------------------------------------------------------------------------
`default_nettype none

module abpf_kraft_stage
    import abpf_pkg::*;
#(
    parameter int FIRST_LEN = 1
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_kraft_bus i_bus,
    output t_kraft_bus      o_bus
);

    t_kraft_bus r_bus;
    t_kraft_bus n_bus;

    // Step through the lengths of this stage
    always_comb begin
        logic [LEFT_W:0] dbl;
        logic [LEFT_W:0] take;
        n_bus = i_bus;
        for (int s = 0; s < KRAFT_STEPS; s++) begin
            dbl  = {n_bus.left, 1'b0};
            take = {{(LEFT_W + 1 - CNT_W){1'b0}}, n_bus.cnt[FIRST_LEN + s]};
            if (dbl < take) begin
                n_bus.fail = 1'b1;
            end else begin
                n_bus.left = LEFT_W'(dbl - take);
            end
        end
    end

    // Hold the valid flag under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus.valid <= n_bus.valid;
        end
    end

    // Advance the payload every cycle
    always_ff @(posedge i_clk) begin
        r_bus.verdict <= n_bus.verdict;
        r_bus.lz_en   <= n_bus.lz_en;
        r_bus.fail    <= n_bus.fail;
        r_bus.left    <= n_bus.left;
        r_bus.cnt     <= n_bus.cnt;
    end

    assign o_bus = r_bus;

endmodule

`default_nettype wire

### hdl/archive_block_plaintext_filter.sv
// The verdict is registered through the front stage, five parse stages,
//   three Kraft stages and the output register.
// Throughput: one block per cycle; every stage is a plain register stage and
//   busy stays low, so start may be held high continuously.
// Reset: synchronous, active low; clears all stage valid flags and restores
//   method_code 48 (stored) and file_kind 2 (png).
// ----------------------------------------------------------------------------
// Archive block plaintext filter - top level
// Screens one decrypted 16-byte first block per cycle against the stored
// signature, PPM flag or LZ code length table rules.
// ----------------------------------------------------------------------------
`default_nettype none

module archive_block_plaintext_filter
    import abpf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [HEAD_W-1:0]     i_block_head,
    input  wire logic [HEAD_W-1:0]     i_block_tail,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_done,
    output logic [VERD_W-1:0]          o_verdict
);

    logic [METHOD_W-1:0] r_method;
    logic [KIND_W-1:0]   r_kind;
    logic                r_done;
    t_verdict            r_verdict;
    t_verdict            n_verdict;

    t_parse_bus parse_bus [0:PARSE_STAGES];
    t_kraft_bus kraft_bus [0:KRAFT_STAGES];
    t_kraft_bus kraft_out;

    // Every stage moves each cycle: never busy
    assign busy = 1'b0;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= METHOD_RESET;
            r_kind   <= KIND_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_METHOD: r_method <= i_cfg_data[METHOD_W-1:0];
                REG_KIND:   r_kind   <= i_cfg_data[KIND_W-1:0];
                default:    ;
            endcase
        end
    end

    abpf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (start && !busy),
        .i_block_head (i_block_head),
        .i_block_tail (i_block_tail),
        .i_method     (r_method),
        .i_kind       (r_kind),
        .o_bus        (parse_bus[0])
    );

    for (genvar g = 0; g < PARSE_STAGES; g++) begin : g_parse
        abpf_parse_stage u_parse (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (parse_bus[g]),
            .o_bus   (parse_bus[g+1])
        );
    end

    // Start the Kraft sum with one unit of code space
    always_comb begin
        kraft_bus[0].valid   = parse_bus[PARSE_STAGES].valid;
        kraft_bus[0].verdict = parse_bus[PARSE_STAGES].verdict;
        kraft_bus[0].lz_en   = parse_bus[PARSE_STAGES].lz_en;
        kraft_bus[0].fail    = 1'b0;
        kraft_bus[0].left    = LEFT_W'(1);
        kraft_bus[0].cnt     = parse_bus[PARSE_STAGES].cnt;
    end

    for (genvar g = 0; g < KRAFT_STAGES; g++) begin : g_kraft
        abpf_kraft_stage #(
            .FIRST_LEN (1 + g*KRAFT_STEPS)
        ) u_kraft (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (kraft_bus[g]),
            .o_bus   (kraft_bus[g+1])
        );
    end

    assign kraft_out = kraft_bus[KRAFT_STAGES];

    // Settle the final verdict; drive reject while no word is out
    always_comb begin
        if (!kraft_out.valid) begin
            n_verdict = VERD_REJECT;
        end else if (kraft_out.lz_en && !kraft_out.fail && kraft_out.left == '0) begin
            n_verdict = VERD_LZ;
        end else begin
            n_verdict = kraft_out.verdict;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= 1'b0;
            r_verdict <= VERD_REJECT;
        end else begin
            r_done    <= kraft_out.valid;
            r_verdict <= n_verdict;
        end
    end

    assign o_done    = r_done;
    assign o_verdict = r_verdict;

endmodule

`default_nettype wire

### hdl/abpf_checker.sv
// ----------------------------------------------------------------------------
// Archive block plaintext filter - port checker
// Watches the top level ports for latency and verdict consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module abpf_checker
    import abpf_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic [HEAD_W-1:0] i_block_head,
    input wire logic              o_done,
    input wire logic [VERD_W-1:0] o_verdict
);

    localparam int SETTLE_W = $clog2(PIPE_LATENCY + 1);

    logic [SETTLE_W-1:0] r_settle;
    logic                settled;

    // Count cycles since reset, saturating at the pipeline depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= '0;
        end else if (r_settle != SETTLE_W'(PIPE_LATENCY)) begin
            r_settle <= r_settle + SETTLE_W'(1);
        end
    end

    assign settled = (r_settle == SETTLE_W'(PIPE_LATENCY));

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy == 1'b0)
        else $error("busy raised");

    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        settled |-> (o_done == $past(start && !busy, PIPE_LATENCY)))
        else $error("done strobe does not follow the accepted word");

    a_quiet_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> (o_verdict == VERD_REJECT))
        else $error("verdict driven without done");

    a_ppm_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (settled && o_done && o_verdict == VERD_PPM) |->
            ($past(i_block_head[63], PIPE_LATENCY) &&
             $past(i_block_head[61], PIPE_LATENCY) &&
             !$past(i_block_head[55], PIPE_LATENCY)))
        else $error("PPM verdict without PPM flag bits");

    a_lz_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (settled && o_done && o_verdict == VERD_LZ) |->
            (!$past(i_block_head[63], PIPE_LATENCY) &&
             !$past(i_block_head[62], PIPE_LATENCY)))
        else $error("LZ verdict with PPM or reset-table flag set");

endmodule

bind archive_block_plaintext_filter abpf_checker u_abpf_checker (.*);

`default_nettype wire
